FILE: rtl/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for scan-line row darkening
// Widths, register codes, reset values and the transaction structs.
// ----------------------------------------------------------------------------
package srd_pkg;

   localparam int ChanWidth     = 16;
   localparam int RowWidth      = 10;
   localparam int DarkWidth     = 16;
   localparam int GainWidth     = 17;
   localparam int GainFracBits  = 16;
   localparam int NumWidth      = DarkWidth + RowWidth;
   localparam int DenWidth      = RowWidth + 1;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam int MaxInterval   = 1023;
   localparam int QueueDepthDefault = 2;

   localparam logic [GainWidth-1:0] GainUnity = GainWidth'(1 << GainFracBits);

   localparam logic [RowWidth-1:0]  IntervalReset = RowWidth'(2);
   localparam logic [RowWidth-1:0]  SmoothReset   = RowWidth'(0);
   localparam logic [DarkWidth-1:0] DarknessReset = DarkWidth'(32768);
   // a centre row always has gain one minus darkness
   localparam logic [GainWidth-1:0] GainReset = GainUnity - GainWidth'(DarknessReset);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LINE_INTERVAL = 2'd0,
      CSR_SMOOTH_ROWS   = 2'd1,
      CSR_DARKNESS      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RowWidth-1:0]  line_interval;
      logic [RowWidth-1:0]  smooth_rows;
      logic [DarkWidth-1:0] darkness;
   } srd_csr_type;

   localparam srd_csr_type CsrReset = '{
      line_interval: IntervalReset,
      smooth_rows:   SmoothReset,
      darkness:      DarknessReset
   };

   typedef struct packed {
      logic [ChanWidth-1:0] red_in;
      logic [ChanWidth-1:0] green_in;
      logic [ChanWidth-1:0] blue_in;
      logic                 frame_start;
      logic                 line_end;
   } srd_req_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red_out;
      logic [ChanWidth-1:0] green_out;
      logic [ChanWidth-1:0] blue_out;
      logic                 line_last;
   } srd_rsp_type;

   // pixel with the gain of its row, queued between front and back
   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic                 line_last;
      logic [GainWidth-1:0] gain;
   } srd_item_type;

   typedef struct packed {
      logic                start;
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
   } srd_div_req_type;

   typedef struct packed {
      logic                done;
      logic [NumWidth-1:0] quot;
   } srd_div_rsp_type;

   typedef struct packed {
      logic idle;
      logic dividing;
   } srd_front_status_type;

endpackage

FILE: rtl/srd_div.sv
// ----------------------------------------------------------------------------
// srd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module srd_div (
   input  logic                    clock,
   input  logic                    reset,
   input  srd_pkg::srd_div_req_type div_req,
   output srd_pkg::srd_div_rsp_type div_rsp
);
   import srd_pkg::*;

   localparam int CountWidth = $clog2(NumWidth);
   localparam logic [CountWidth-1:0] CountLast = CountWidth'(NumWidth - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [NumWidth-1:0]   work_ff, work_in;
   logic [DenWidth-1:0]   rem_ff, rem_in;
   logic [DenWidth-1:0]   den_ff, den_in;
   logic [DenWidth:0]     trial;
   logic [DenWidth:0]     diff;
   logic                  fits;

   assign trial = {rem_ff, work_ff[NumWidth-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         work_in  = div_req.num;
         rem_in   = '0;
         den_in   = div_req.den;
      end else if (busy_ff) begin
         // shift in the next dividend bit, shift out one quotient bit
         rem_in   = fits ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
         work_in  = {work_ff[NumWidth-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CountLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = work_ff;

endmodule

FILE: rtl/srd_fifo.sv
// ----------------------------------------------------------------------------
// srd_fifo: short queue between front and back
// Register slots with wrap-around pointers and an occupancy count.
// ----------------------------------------------------------------------------
module srd_fifo #(
   parameter int DEPTH = srd_pkg::QueueDepthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  srd_pkg::srd_item_type        push_data,
   input  logic                         pop,
   output logic                         valid,
   output srd_pkg::srd_item_type        pop_data,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import srd_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   srd_item_type        slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CntFull);
   assign valid    = (count_ff != '0);
   assign count    = count_ff;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/srd_front.sv
// ----------------------------------------------------------------------------
// srd_front: row tracking and gain selection
// Accepts pixels, tags each with its row gain and works out the next row's
// gain after a line end, using the divider for graded rows.
// ----------------------------------------------------------------------------
module srd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  srd_pkg::srd_req_type          req_data,
   input  srd_pkg::srd_csr_type          csr,
   input  logic                          queue_full,
   output logic                          push,
   output srd_pkg::srd_item_type         push_data,
   output srd_pkg::srd_div_req_type      div_req,
   input  srd_pkg::srd_div_rsp_type      div_rsp,
   output srd_pkg::srd_front_status_type status
);
   import srd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DIV  = 3'b100
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [RowWidth-1:0]  row_phase_ff, row_phase_in;
   logic [GainWidth-1:0] row_gain_ff, row_gain_in;
   logic [RowWidth-1:0]  snap_iv_ff, snap_iv_in;
   logic [RowWidth-1:0]  snap_smooth_ff, snap_smooth_in;
   logic [DarkWidth-1:0] snap_dark_ff, snap_dark_in;

   logic                 accept;
   logic [RowWidth-1:0]  eff_iv;
   logic [GainWidth-1:0] center_gain;
   logic [RowWidth-1:0]  base_phase;
   logic [RowWidth-1:0]  next_raw;
   logic [RowWidth-1:0]  next_phase;
   logic [RowWidth-1:0]  up_dist;
   logic [RowWidth-1:0]  row_dist;
   logic [RowWidth-1:0]  weight;
   logic                 graded;

   assign req_stall = (state_ff != ST_IDLE) || queue_full;
   assign accept    = req_valid && !req_stall;

   // clamp the interval to one at the low end and the maximum at the top
   always_comb begin
      if (csr.line_interval == '0) begin
         eff_iv = RowWidth'(1);
      end else if (int'(csr.line_interval) > MaxInterval) begin
         eff_iv = RowWidth'(MaxInterval);
      end else begin
         eff_iv = csr.line_interval;
      end
   end

   assign center_gain = GainUnity - GainWidth'(csr.darkness);
   assign base_phase  = req_data.frame_start ? '0 : row_phase_ff;
   assign next_raw    = base_phase + 1'b1;
   assign next_phase  = (next_raw >= eff_iv) ? '0 : next_raw;

   assign push                = accept;
   assign push_data.red       = req_data.red_in;
   assign push_data.green     = req_data.green_in;
   assign push_data.blue      = req_data.blue_in;
   assign push_data.line_last = req_data.line_end;
   assign push_data.gain      = req_data.frame_start ? center_gain : row_gain_ff;

   // distance to the nearest centre, above or below
   assign up_dist  = snap_iv_ff - row_phase_ff;
   assign row_dist = (up_dist < row_phase_ff) ? up_dist : row_phase_ff;
   assign weight   = snap_smooth_ff - row_dist + 1'b1;
   assign graded   = (row_dist != '0) && (row_dist <= snap_smooth_ff);

   assign div_req.start = (state_ff == ST_CALC) && graded;
   assign div_req.num   = NumWidth'(snap_dark_ff) * NumWidth'(weight);
   assign div_req.den   = {1'b0, snap_smooth_ff} + 1'b1;

   assign status.idle     = (state_ff == ST_IDLE);
   assign status.dividing = (state_ff == ST_DIV);

   always_comb begin
      state_in       = state_ff;
      row_phase_in   = row_phase_ff;
      row_gain_in    = row_gain_ff;
      snap_iv_in     = snap_iv_ff;
      snap_smooth_in = snap_smooth_ff;
      snap_dark_in   = snap_dark_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.frame_start) begin
                  row_phase_in = '0;
                  row_gain_in  = center_gain;
               end
               if (req_data.line_end) begin
                  // hold the registers so a later write hits the next row only
                  row_phase_in   = next_phase;
                  snap_iv_in     = eff_iv;
                  snap_smooth_in = csr.smooth_rows;
                  snap_dark_in   = csr.darkness;
                  state_in       = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (row_dist == '0) begin
               row_gain_in = GainUnity - GainWidth'(snap_dark_ff);
               state_in    = ST_IDLE;
            end else if (!graded) begin
               row_gain_in = GainUnity;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               row_gain_in = GainUnity - GainWidth'(div_rsp.quot);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_phase_ff <= '0;
         row_gain_ff  <= GainReset;
      end else begin
         state_ff     <= state_in;
         row_phase_ff <= row_phase_in;
         row_gain_ff  <= row_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_iv_ff     <= snap_iv_in;
      snap_smooth_ff <= snap_smooth_in;
      snap_dark_ff   <= snap_dark_in;
   end

endmodule

FILE: rtl/srd_back.sv
// ----------------------------------------------------------------------------
// srd_back: channel scaling and result register
// Multiplies each channel by its row gain and holds the result transaction.
// ----------------------------------------------------------------------------
module srd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  srd_pkg::srd_item_type item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srd_pkg::srd_rsp_type  rsp_data
);
   import srd_pkg::*;

   localparam int ProdWidth = ChanWidth + GainWidth;

   logic                 rsp_valid_ff, rsp_valid_in;
   srd_rsp_type          rsp_data_ff, rsp_data_in;
   logic                 load;
   logic [ProdWidth-1:0] red_prod;
   logic [ProdWidth-1:0] green_prod;
   logic [ProdWidth-1:0] blue_prod;

   assign load = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load;

   assign red_prod   = ProdWidth'(item.red) * ProdWidth'(item.gain);
   assign green_prod = ProdWidth'(item.green) * ProdWidth'(item.gain);
   assign blue_prod  = ProdWidth'(item.blue) * ProdWidth'(item.gain);

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in.red_out   = red_prod[GainFracBits +: ChanWidth];
         rsp_data_in.green_out = green_prod[GainFracBits +: ChanWidth];
         rsp_data_in.blue_out  = blue_prod[GainFracBits +: ChanWidth];
         rsp_data_in.line_last = item.line_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/scanline_row_darkening.sv
// ----------------------------------------------------------------------------
// scanline_row_darkening: CRT scan-line darkening on a raster pixel stream
// Path: an accepted pixel is written into a queue slot, then scaled into the
// result register. Throughput: 1 pixel per cycle within a row while the queue
// is not full; after a line_end pixel the front holds stall in its calc state,
// and also while the one-bit-per-cycle divider runs when the next row is graded.
// Reset: synchronous; registers return to interval 2, smoothing 0, darkness
// one half, row phase 0, and the queue and output register are emptied.
// ----------------------------------------------------------------------------
module scanline_row_darkening #(
   parameter int QUEUE_DEPTH = srd_pkg::QueueDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  srd_pkg::srd_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output srd_pkg::srd_rsp_type               rsp_data,
   input  logic                               csr_write_en,
   input  logic [srd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [srd_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import srd_pkg::*;

   srd_csr_type                      csr_ff, csr_in;
   logic                             queue_push;
   srd_item_type                     queue_push_data;
   logic                             queue_pop;
   logic                             queue_valid;
   srd_item_type                     queue_pop_data;
   logic                             queue_full;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;
   srd_div_req_type                  div_req;
   srd_div_rsp_type                  div_rsp;
   srd_front_status_type             front_status;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_INTERVAL: csr_in.line_interval = csr_wdata[RowWidth-1:0];
            CSR_SMOOTH_ROWS:   csr_in.smooth_rows   = csr_wdata[RowWidth-1:0];
            CSR_DARKNESS:      csr_in.darkness      = csr_wdata[DarkWidth-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CsrReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   srd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr        (csr_ff),
      .queue_full (queue_full),
      .push       (queue_push),
      .push_data  (queue_push_data),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .status     (front_status)
   );

   srd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   srd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_push_data),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_data  (queue_pop_data),
      .full      (queue_full),
      .count     (queue_count)
   );

   srd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_pop_data),
      .pop        (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // the front must refuse pixels while the next row's gain is pending
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      !front_status.idle |-> req_stall)
      else $error("pixel could be accepted while row gain is pending");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> front_status.dividing)
      else $error("divider finished while front was not waiting for it");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_full)
      else $error("push into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(queue_count) <= QUEUE_DEPTH)
      else $error("queue count beyond depth");

endmodule

FILE: tb/scanline_row_darkening_scoreboard.sv
// ----------------------------------------------------------------------------
// scanline_row_darkening_scoreboard: pixel predictor and result comparison
// Watches the pixel, result and register ports and keeps its own row phase,
// row gain and register copy. It works out the darkened pixel for every
// accepted input and compares it with the oldest outstanding result.
// ----------------------------------------------------------------------------
module scanline_row_darkening_scoreboard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  srd_pkg::srd_req_type              req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  srd_pkg::srd_rsp_type              rsp_data,
   input  logic                              csr_write_en,
   input  logic [srd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [srd_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                pending_pixels,
   output int                                error_count
);
   import srd_pkg::*;

   srd_csr_type          regs;
   logic [RowWidth-1:0]  row_phase;
   logic [RowWidth-1:0]  next_phase;
   logic [GainWidth-1:0] row_gain;
   srd_rsp_type          darkened_pixel;
   srd_rsp_type          oldest_pixel;
   srd_rsp_type          expected_pixels[$];

   initial begin
      pending_pixels = 0;
      error_count = 0;
   end

   // zero acts as one, and the top is clamped
   function automatic int unsigned interval_in_use(input srd_csr_type r);
      int unsigned iv;
      iv = r.line_interval;
      if (iv < 1) iv = 1;
      if (iv > MaxInterval) iv = MaxInterval;
      return iv;
   endfunction

   function automatic logic [GainWidth-1:0] row_gain_for(input logic [RowWidth-1:0] phase,
                                                         input srd_csr_type r);
      int unsigned      iv;
      int unsigned      ph;
      int unsigned      center_dist;
      int unsigned      den;
      longint unsigned  prod;
      iv = interval_in_use(r);
      ph = phase;
      if (ph >= iv) ph = 0;
      // nearest centre, above or below
      center_dist = (iv - ph < ph) ? iv - ph : ph;
      if (center_dist == 0) return GainUnity - GainWidth'(r.darkness);
      if (center_dist <= r.smooth_rows) begin
         den = r.smooth_rows + 1;
         prod = r.darkness;
         prod = prod * (den - center_dist);
         return GainUnity - GainWidth'(prod / den);
      end
      return GainUnity;
   endfunction

   function automatic logic [ChanWidth-1:0] darken_channel(input logic [ChanWidth-1:0] ch,
                                                           input logic [GainWidth-1:0] gain);
      longint unsigned prod;
      prod = ch;
      prod = prod * gain;
      return ChanWidth'(prod >> GainFracBits);
   endfunction

   task automatic compare_field(input string name, input logic [ChanWidth-1:0] want,
                                input logic [ChanWidth-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs = CsrReset;
         row_phase = '0;
         row_gain = row_gain_for('0, CsrReset);
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result transaction with nothing outstanding: %p", rsp_data);
               error_count++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               compare_field("red_out", oldest_pixel.red_out, rsp_data.red_out);
               compare_field("green_out", oldest_pixel.green_out, rsp_data.green_out);
               compare_field("blue_out", oldest_pixel.blue_out, rsp_data.blue_out);
               compare_field("line_last", ChanWidth'(oldest_pixel.line_last),
                             ChanWidth'(rsp_data.line_last));
            end
         end

         // a write only changes the registers; the gain follows at the next row start
         if (csr_write_en) begin
            case (csr_index)
               CSR_LINE_INTERVAL: regs.line_interval = csr_wdata[RowWidth-1:0];
               CSR_SMOOTH_ROWS:   regs.smooth_rows = csr_wdata[RowWidth-1:0];
               CSR_DARKNESS:      regs.darkness = csr_wdata[DarkWidth-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            if (req_data.frame_start) begin
               row_phase = '0;
               row_gain = row_gain_for('0, regs);
            end
            darkened_pixel.red_out = darken_channel(req_data.red_in, row_gain);
            darkened_pixel.green_out = darken_channel(req_data.green_in, row_gain);
            darkened_pixel.blue_out = darken_channel(req_data.blue_in, row_gain);
            darkened_pixel.line_last = req_data.line_end;
            expected_pixels.push_back(darkened_pixel);
            if (req_data.line_end) begin
               next_phase = row_phase + 1'b1;
               if (next_phase >= interval_in_use(regs)) next_phase = '0;
               row_phase = next_phase;
               row_gain = row_gain_for(next_phase, regs);
            end
         end
      end
      pending_pixels = expected_pixels.size();
   end

endmodule

FILE: tb/scanline_row_darkening_tb.sv
// ----------------------------------------------------------------------------
// scanline_row_darkening_tb: stimulus and verdict for scan-line darkening
// Drives a short directed pixel sequence, then random frames of rows under
// many register settings with random idling on both channels. A scoreboard
// beside the block predicts every darkened pixel and counts mismatches.
// ----------------------------------------------------------------------------
module scanline_row_darkening_tb;
   import srd_pkg::*;

   localparam int RANDOM_PIXELS  = 1850;
   localparam int CALM_PIXELS    = 250;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   srd_req_type              req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   srd_rsp_type              rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_LINE_INTERVAL;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   int pending_pixels;
   int error_count;
   int idle_cycles = 0;
   int pixels_sent = 0;
   int rows_ended = 0;
   int frames_started = 0;
   int settings_used = 1;
   int gap_pct = 0;
   int stall_pct = 0;
   int calm_start = 1 << 30;
   bit calm = 1'b0;
   int idle_rates[4] = '{0, 5, 15, 35};

   always #5 clock = ~clock;

   scanline_row_darkening uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   scanline_row_darkening_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_pixels (pending_pixels),
      .error_count    (error_count)
   );

   // receiver: stall in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic srd_req_type make_pixel(input logic [ChanWidth-1:0] r,
                                              input logic [ChanWidth-1:0] g,
                                              input logic [ChanWidth-1:0] b,
                                              input logic fs, input logic le);
      srd_req_type px;
      px.red_in = r;
      px.green_in = g;
      px.blue_in = b;
      px.frame_start = fs;
      px.line_end = le;
      return px;
   endfunction

   function automatic logic [ChanWidth-1:0] random_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return ChanWidth'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input srd_req_type px);
      // drop all idling once the closing stretch is reached
      calm = (pixels_sent > calm_start);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      if (px.line_end) rows_ended++;
      if (px.frame_start) frames_started++;
   endtask

   // drop valid, drain every result, then let a pending row division finish
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_pixels != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // one frame of rows; a few stray marks and a cut-off last row now and then
   task automatic send_frame(input int rows_max);
      int          rows;
      int          width;
      int          r;
      int          c;
      bit          cut;
      srd_req_type px;
      rows = $urandom_range(1, rows_max);
      cut = ($urandom_range(0, 7) == 0);
      for (r = 0; r < rows; r++) begin
         width = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
         for (c = 0; c < width; c++) begin
            px = make_pixel(random_channel(), random_channel(), random_channel(),
                            r == 0 && c == 0, c == width - 1 && !(cut && r == rows - 1));
            if ($urandom_range(0, 99) < 6) begin
               px.frame_start = $urandom_range(0, 1);
               px.line_end = $urandom_range(0, 1);
            end
            send_pixel(px);
         end
      end
   endtask

   initial begin
      int          random_target;
      int          phase_end;
      int          rows_max;
      logic [RowWidth-1:0]  interval;
      logic [RowWidth-1:0]  smooth;
      logic [DarkWidth-1:0] dark;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: interval 2, no smoothing, half darkness
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
      send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'h8000, 16'h0001, 1'b0, 1'b1));
      // both marks on one pixel
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      send_pixel(make_pixel(16'h1234, 16'hABCD, 16'hFFFF, 1'b0, 1'b1));

      // zero interval: every row is a centre; upper data bits are ignored
      settle();
      write_reg(CSR_LINE_INTERVAL, 16'hFC00);
      send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1));
      send_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1));

      // largest interval, widest smoothing, full darkness
      settle();
      write_reg(CSR_LINE_INTERVAL, 16'd1023);
      write_reg(CSR_SMOOTH_ROWS, 16'd1023);
      write_reg(CSR_DARKNESS, 16'hFFFF);
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'h7FFF, 16'h0000, 1'b0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'h5555, 16'hAAAA, 1'b0, 1'b1));

      // shrink the interval below the current phase mid-frame: gain holds, then wrap
      settle();
      write_reg(CSR_LINE_INTERVAL, 16'd3);
      write_reg(CSR_SMOOTH_ROWS, 16'd2);
      write_reg(CSR_UNUSED_INDEX, 16'h0001);
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));

      // no darkness at all
      settle();
      write_reg(CSR_DARKNESS, 16'h0000);
      send_pixel(make_pixel(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, 1'b0));
      settings_used += 4;

      random_target = pixels_sent + RANDOM_PIXELS;
      calm_start = random_target - CALM_PIXELS;
      while (pixels_sent < random_target) begin
         settle();
         case ($urandom_range(0, 7))
            0: interval = '0;
            1: interval = 10'd1;
            2: interval = 10'd1023;
            3: interval = RowWidth'($urandom_range(0, 1023));
            default: interval = RowWidth'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 5))
            0: smooth = '0;
            1: smooth = 10'd1023;
            2: smooth = RowWidth'($urandom_range(0, 1023));
            default: smooth = RowWidth'($urandom_range(0, interval));
         endcase
         case ($urandom_range(0, 5))
            0: dark = '0;
            1: dark = '1;
            default: dark = DarkWidth'($urandom);
         endcase
         write_reg(CSR_LINE_INTERVAL, {6'($urandom), interval});
         write_reg(CSR_SMOOTH_ROWS, {6'($urandom), smooth});
         write_reg(CSR_DARKNESS, dark);
         if ($urandom_range(0, 9) == 0) write_reg(CSR_UNUSED_INDEX, 16'($urandom));
         settings_used++;
         gap_pct = idle_rates[$urandom_range(0, 3)];
         stall_pct = idle_rates[$urandom_range(0, 3)];
         rows_max = (interval <= 16) ? 2 * interval + 4 : 40;
         phase_end = pixels_sent + $urandom_range(60, 160);
         while (pixels_sent < phase_end) send_frame(rows_max);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_pixels != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Covered %0d pixels, %0d row ends and %0d frame starts",
               pixels_sent, rows_ended, frames_started);
      $display("under %0d register settings, with random idling on both channels",
               settings_used);
      $display("and a final stretch at full rate.");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/srd_pkg.sv
rtl/srd_div.sv
rtl/srd_fifo.sv
rtl/srd_front.sv
rtl/srd_back.sv
rtl/scanline_row_darkening.sv
tb/scanline_row_darkening_scoreboard.sv
tb/scanline_row_darkening_tb.sv
